// File: hdl/isc_pkg.sv
// Shared types and constants for the interval stabbing counter.
// Depends on nothing; every other file imports it.
package isc_pkg;

  // Fixed widths of the item fields.
  localparam int FieldBits = 32;
  localparam int CountBits = 9;
  localparam logic [CountBits-1:0] COUNT_MAX = 9'd511;

  // Action codes carried by an input item.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Control travelling with each slot of the cell chain.
  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

endpackage

// File: hdl/isc_if.sv
// Valid/ready channel interfaces for the interval stabbing counter.
// Depends on isc_pkg for the field widths.
interface isc_in_if
  import isc_pkg::*;
  ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic signed [FieldBits-1:0] seg_start;
  logic signed [FieldBits-1:0] seg_end;
  logic signed [FieldBits-1:0] query_point;

  modport source (output valid, action, seg_start, seg_end, query_point, input ready);
  modport sink   (input valid, action, seg_start, seg_end, query_point, output ready);
endinterface

interface isc_out_if
  import isc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CountBits-1:0] covering_count;

  modport source (output valid, covering_count, input ready);
  modport sink   (input valid, covering_count, output ready);
endinterface

// File: hdl/interval_stabbing_counter.sv
// Top level of the interval stabbing counter: input decode, cell chain, output register.
// Depends on isc_pkg, isc_if (channel interfaces) and isc_cell.
//
//   channel  | dir | payload
//   ---------+-----+----------------------------------------------
//   in_ch    | in  | action, seg_start, seg_end, query_point
//   out_ch   | out | covering_count (one item for each query)
//
// Every item walks the chain, one cell a cycle while the chain moves, so one item
// is accepted each cycle unless the output stalls; a query result passes through
// every cell of the chain (one cell per stored segment) and then the output register.
// Reset clears the fill count and the valid bit of every cell at once.
// A result waiting in the output register with ready low freezes the whole
// chain and holds in_ch.ready low until the result is taken.
module interval_stabbing_counter
  import isc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst,
  isc_in_if.sink       in_ch,
  isc_out_if.source    out_ch
);

  localparam int CW    = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int MW    = (CNT_W > CountBits) ? CNT_W : CountBits;

  ctl_t                 chain_ctl [MAX_SEGMENTS+1];
  logic signed [CW-1:0] chain_a   [MAX_SEGMENTS+1];
  logic signed [CW-1:0] chain_b   [MAX_SEGMENTS+1];
  logic [IDX_W-1:0]     chain_idx [MAX_SEGMENTS+1];
  logic [CNT_W-1:0]     chain_cnt [MAX_SEGMENTS+1];

  logic                 adv;
  logic                 accept;
  logic                 full;
  logic [CNT_W-1:0]     stored_total;
  logic [CNT_W-1:0]     stored_total_next;
  op_t                  op;
  logic                 inject;
  logic                 out_vld;
  logic [CountBits-1:0] out_cnt;
  logic [MW-1:0]        tail_ext;
  ctl_t                 tail_ctl;

  // The chain moves whenever the output register is free or being emptied.
  assign adv          = !out_vld || out_ch.ready;
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;
  assign op           = op_t'(in_ch.action);
  assign full         = (stored_total == CNT_W'(MAX_SEGMENTS));

  // Decide whether an accepted item enters the chain and update the fill count.
  always_comb begin
    stored_total_next = stored_total;
    inject            = 1'b0;
    unique case (op)
      OP_CLEAR: begin
        inject            = accept;
        stored_total_next = accept ? '0 : stored_total;
      end
      OP_ADD: begin
        inject            = accept && !full;
        stored_total_next = (accept && !full) ? stored_total + CNT_W'(1) : stored_total;
      end
      OP_QUERY: begin
        inject = accept;
      end
      default: begin
        inject = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_total <= '0;
    end else begin
      stored_total <= stored_total_next;
    end
  end

  // Head of the chain: a query carries its point in the first coordinate lane.
  assign chain_ctl[0].vld = inject;
  assign chain_ctl[0].op  = op;
  assign chain_a[0]   = (op == OP_QUERY) ? $signed(in_ch.query_point[CW-1:0])
                                         : $signed(in_ch.seg_start[CW-1:0]);
  assign chain_b[0]   = $signed(in_ch.seg_end[CW-1:0]);
  assign chain_idx[0] = stored_total[IDX_W-1:0];
  assign chain_cnt[0] = '0;

  // One cell for each stored segment.
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    isc_cell #(
      .CW      (CW),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .CELL_ID (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (chain_ctl[i]),
      .a_in    (chain_a[i]),
      .b_in    (chain_b[i]),
      .idx_in  (chain_idx[i]),
      .cnt_in  (chain_cnt[i]),
      .ctl_out (chain_ctl[i+1]),
      .a_out   (chain_a[i+1]),
      .b_out   (chain_b[i+1]),
      .idx_out (chain_idx[i+1]),
      .cnt_out (chain_cnt[i+1])
    );
  end

  assign tail_ctl = chain_ctl[MAX_SEGMENTS];
  assign tail_ext = MW'(chain_cnt[MAX_SEGMENTS]);

  // Output register: catches query items leaving the chain, count clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= tail_ctl.vld && (tail_ctl.op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cnt <= (tail_ext > MW'(COUNT_MAX)) ? COUNT_MAX : tail_ext[CountBits-1:0];
    end
  end

  assign out_ch.valid          = out_vld;
  assign out_ch.covering_count = out_cnt;

  // The fill count never passes the chain length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stored_total <= CNT_W'(MAX_SEGMENTS))
    else $error("fill count beyond capacity");

  // An accepted clear resets the fill count on the next cycle.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_CLEAR) |=> stored_total == '0)
    else $error("clear did not reset fill count");

  // A query leaving the chain while it moves is presented at the output.
  a_result: assert property (@(posedge clk) disable iff (rst)
    adv && tail_ctl.vld && (tail_ctl.op == OP_QUERY) |=> out_ch.valid)
    else $error("query result lost at chain tail");

  // While the chain is stalled its tail does not move.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(tail_ctl.vld) && $stable(chain_cnt[MAX_SEGMENTS]))
    else $error("chain moved during stall");

endmodule

// File: hdl/isc_cell.sv
// One cell of the segment chain: holds one stored segment and passes one item a cycle while en is high.
// Depends on isc_pkg for the control struct and action codes.
module isc_cell
  import isc_pkg::*;
#(
  parameter int CW      = 32,
  parameter int IDX_W   = 8,
  parameter int CNT_W   = 9,
  parameter int CELL_ID = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic signed [CW-1:0] a_in,
  input  logic signed [CW-1:0] b_in,
  input  logic [IDX_W-1:0]     idx_in,
  input  logic [CNT_W-1:0]     cnt_in,
  output ctl_t                 ctl_out,
  output logic signed [CW-1:0] a_out,
  output logic signed [CW-1:0] b_out,
  output logic [IDX_W-1:0]     idx_out,
  output logic [CNT_W-1:0]     cnt_out
);

  logic                 seg_vld;
  logic signed [CW-1:0] seg_lo;
  logic signed [CW-1:0] seg_hi;
  logic                 hit;
  logic                 mine;

  // A query hits when this cell holds a segment that covers the point.
  assign hit  = ctl_in.vld && (ctl_in.op == OP_QUERY) && seg_vld &&
                (seg_lo <= a_in) && (a_in <= seg_hi);
  assign mine = ctl_in.vld && (ctl_in.op == OP_ADD) && (idx_in == IDX_W'(CELL_ID));

  // Stored segment: cleared by a clear item, loaded by an add aimed at this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_vld <= 1'b0;
    end else if (en) begin
      if (ctl_in.vld && (ctl_in.op == OP_CLEAR)) begin
        seg_vld <= 1'b0;
      end else if (mine) begin
        seg_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && mine) begin
      seg_lo <= a_in;
      seg_hi <= b_in;
    end
  end

  // Hand the item on to the next cell; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl_out.op <= ctl_in.op;
      a_out      <= a_in;
      b_out      <= b_in;
      idx_out    <= idx_in;
      cnt_out    <= cnt_in + CNT_W'(hit);
    end
  end

endmodule
